// File: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on clk, off while arst_n is low
`define ATA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication sampled on clk, off while arst_n is low
`define ATA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication sampled on clk, off while arst_n is low
`define ATA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/ata_pkg.sv
// types, constants and cordic functions for the tilt angle block
`default_nettype none
package ata_pkg;

	localparam int DATA_W      = 16;
	localparam int ROLL_W      = 17;
	localparam int PITCH_W     = 16;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 40;

	localparam int ANGLE_FRAC_BITS_DEF = 8;
	localparam int CORDIC_STAGES_DEF   = 16;

	localparam int ACC_FRAC  = 20;
	localparam int TABLE_LEN = 24;
	localparam int SQ_W      = 48;
	localparam int ROOT_W    = 24;
	localparam int CW        = 44;
	localparam int ZW        = 30;

	localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(94371840);
	localparam int ROLL_LIMIT_DEG  = 180;
	localparam int PITCH_LIMIT_DEG = 90;

	typedef struct packed {
		logic        [SQ_W-1:0]   rem;
		logic        [ROOT_W-1:0] root;
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] z;
	} ata_sqrt_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] ang;
		logic                 zero;
	} ata_lane_t;

	typedef struct packed {
		ata_lane_t roll;
		ata_lane_t pitch;
	} ata_pair_t;

	function automatic logic [ZW-1:0] atan_q20(input int unsigned i);
		logic [ZW-1:0] t;
		case (i)
			0:  t = ZW'(47185920);
			1:  t = ZW'(27855475);
			2:  t = ZW'(14718068);
			3:  t = ZW'(7471121);
			4:  t = ZW'(3750058);
			5:  t = ZW'(1876857);
			6:  t = ZW'(938658);
			7:  t = ZW'(469357);
			8:  t = ZW'(234682);
			9:  t = ZW'(117342);
			10: t = ZW'(58671);
			11: t = ZW'(29335);
			12: t = ZW'(14668);
			13: t = ZW'(7334);
			14: t = ZW'(3667);
			15: t = ZW'(1833);
			16: t = ZW'(917);
			17: t = ZW'(458);
			18: t = ZW'(229);
			19: t = ZW'(115);
			20: t = ZW'(57);
			21: t = ZW'(29);
			22: t = ZW'(14);
			23: t = ZW'(7);
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic ata_lane_t cordic_rot(input ata_lane_t c, input int unsigned i);
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;
		logic signed [ZW-1:0] t;
		ata_lane_t            r;
		xs = c.x >>> i;
		ys = c.y >>> i;
		t  = signed'(atan_q20(i));
		r  = c;
		if (!c.y[CW-1]) begin
			r.x   = c.x + ys;
			r.y   = c.y - xs;
			r.ang = c.ang + t;
		end else begin
			r.x   = c.x - ys;
			r.y   = c.y + xs;
			r.ang = c.ang - t;
		end
		return r;
	endfunction

	function automatic ata_lane_t prerotate(input logic signed [CW-1:0] num,
			input logic signed [CW-1:0] den);
		ata_lane_t r;
		r.zero = (num == '0) && (den == '0);
		r.x    = den;
		r.y    = num;
		r.ang  = '0;
		if (den[CW-1]) begin
			if (!num[CW-1]) begin
				r.x   = num;
				r.y   = -den;
				r.ang = QUARTER_TURN;
			end else begin
				r.x   = -num;
				r.y   = den;
				r.ang = -QUARTER_TURN;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: src/accel_tilt_angles_core.sv
// top level: roll and pitch tilt angles from one accelerometer sample
// Takes one signed x, y, z sample per cycle while s_tready is high and returns
// roll = atan2(y, z) and pitch = atan2(-x, sqrt(y*y + z*z)) in degrees with
// ANGLE_FRAC_BITS fraction bits, both saturated (roll to +-180, pitch to +-90);
// atan2(0, 0) gives 0. Throughput is one item per cycle while s_tready is high.
// From acceptance to m_tvalid a sample passes one input stage with the squaring
// multipliers, 24 square root cells (one result bit each), one quadrant stage,
// one cordic cell per stage shared by both angles, one rounding stage and a
// two-entry output queue. The pipeline advances while the queue has room, so
// s_tready drops only once two finished results wait at the output.
`default_nettype none
module accel_tilt_angles_core #(
	parameter int ANGLE_FRAC_BITS = ata_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = ata_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// accel_x, accel_y, accel_z
	input  wire logic [ata_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// roll_angle, pitch_angle, zero padding
	output logic      [ata_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	localparam int NSTG  = (CORDIC_STAGES < ata_pkg::TABLE_LEN) ? CORDIC_STAGES
		: ata_pkg::TABLE_LEN;
	localparam int SH    = ata_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
	localparam int RW    = ata_pkg::ZW + 1;
	localparam logic signed [RW-1:0] HALF = RW'(1) << (SH - 1);
	localparam logic signed [RW-1:0] ROLL_LIM = RW'(ata_pkg::ROLL_LIMIT_DEG) <<
		ANGLE_FRAC_BITS;
	localparam logic signed [RW-1:0] PITCH_LIM = RW'(ata_pkg::PITCH_LIMIT_DEG) <<
		ANGLE_FRAC_BITS;
	localparam int DW = ata_pkg::DATA_W;

	logic en;
	logic fifo_full;

	// input stage with squares
	logic                 valid_s1;
	logic signed [DW-1:0] x_s1;
	logic signed [DW-1:0] y_s1;
	logic signed [DW-1:0] z_s1;
	logic [2*DW-2:0]      yy_s1;
	logic [2*DW-2:0]      zz_s1;
	logic signed [2*DW-1:0] yy_c;
	logic signed [2*DW-1:0] zz_c;

	assign en       = ~fifo_full;
	assign s_tready = en;

	assign yy_c = signed'(s_tdata[2*DW-1:DW]) * signed'(s_tdata[2*DW-1:DW]);
	assign zz_c = signed'(s_tdata[3*DW-1:2*DW]) * signed'(s_tdata[3*DW-1:2*DW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= s_tdata[DW-1:0];
			y_s1  <= s_tdata[2*DW-1:DW];
			z_s1  <= s_tdata[3*DW-1:2*DW];
			yy_s1 <= yy_c[2*DW-2:0];
			zz_s1 <= zz_c[2*DW-2:0];
		end
	end

	// square root chain
	logic               sq_v [ata_pkg::ROOT_W+1];
	ata_pkg::ata_sqrt_t sq_d [ata_pkg::ROOT_W+1];
	logic [2*DW-1:0]    sum_c;

	always_comb begin
		sum_c          = {1'b0, yy_s1} + {1'b0, zz_s1};
		sq_v[0]        = valid_s1;
		sq_d[0].rem    = {sum_c, 16'd0};
		sq_d[0].root   = '0;
		sq_d[0].x      = x_s1;
		sq_d[0].y      = y_s1;
		sq_d[0].z      = z_s1;
	end

	for (genvar k = 0; k < ata_pkg::ROOT_W; k++) begin : g_sqrt
		ata_sqrt_cell #(
			.BIT(ata_pkg::ROOT_W - 1 - k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (sq_v[k]),
			.in_data  (sq_d[k]),
			.out_valid(sq_v[k+1]),
			.out_data (sq_d[k+1])
		);
	end

	// quadrant stage
	logic signed [ata_pkg::CW-1:0] roll_num;
	logic signed [ata_pkg::CW-1:0] roll_den;
	logic signed [ata_pkg::CW-1:0] pitch_num;
	logic signed [ata_pkg::CW-1:0] pitch_den;
	ata_pkg::ata_pair_t            pre_c;
	logic                          pre_v_s2;
	ata_pkg::ata_pair_t            pre_s2;
	ata_pkg::ata_sqrt_t            sq_last;

	assign sq_last = sq_d[ata_pkg::ROOT_W];

	always_comb begin
		roll_num  = ata_pkg::CW'(sq_last.y) <<< 16;
		roll_den  = ata_pkg::CW'(sq_last.z) <<< 16;
		pitch_num = (-ata_pkg::CW'(sq_last.x)) <<< 24;
		pitch_den = ata_pkg::CW'({1'b0, sq_last.root}) <<< 16;
		pre_c.roll  = ata_pkg::prerotate(roll_num, roll_den);
		pre_c.pitch = ata_pkg::prerotate(pitch_num, pitch_den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_v_s2 <= 1'b0;
		end else if (en) begin
			pre_v_s2 <= sq_v[ata_pkg::ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s2 <= pre_c;
		end
	end

	// cordic chain
	logic               cd_v [NSTG+1];
	ata_pkg::ata_pair_t cd_d [NSTG+1];

	assign cd_v[0] = pre_v_s2;
	assign cd_d[0] = pre_s2;

	for (genvar i = 0; i < NSTG; i++) begin : g_cordic
		ata_cordic_cell #(
			.STAGE(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (cd_v[i]),
			.in_data  (cd_d[i]),
			.out_valid(cd_v[i+1]),
			.out_data (cd_d[i+1])
		);
	end

	// rounding and saturation
	ata_pkg::ata_pair_t         cd_last;
	logic signed [RW-1:0]       roll_r;
	logic signed [RW-1:0]       pitch_r;
	logic signed [RW-1:0]       roll_c;
	logic signed [RW-1:0]       pitch_c;
	logic                       rnd_v_s3;
	logic [ata_pkg::ROLL_W-1:0] roll_s3;
	logic [ata_pkg::PITCH_W-1:0] pitch_s3;

	assign cd_last = cd_d[NSTG];

	always_comb begin
		roll_r  = (RW'(cd_last.roll.ang) + HALF) >>> SH;
		pitch_r = (RW'(cd_last.pitch.ang) + HALF) >>> SH;
		roll_c  = roll_r;
		pitch_c = pitch_r;
		if (roll_r > ROLL_LIM) begin
			roll_c = ROLL_LIM;
		end else if (roll_r < -ROLL_LIM) begin
			roll_c = -ROLL_LIM;
		end
		if (pitch_r > PITCH_LIM) begin
			pitch_c = PITCH_LIM;
		end else if (pitch_r < -PITCH_LIM) begin
			pitch_c = -PITCH_LIM;
		end
		if (cd_last.roll.zero) begin
			roll_c = '0;
		end
		if (cd_last.pitch.zero) begin
			pitch_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_v_s3 <= 1'b0;
		end else if (en) begin
			rnd_v_s3 <= cd_v[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_s3  <= roll_c[ata_pkg::ROLL_W-1:0];
			pitch_s3 <= pitch_c[ata_pkg::PITCH_W-1:0];
		end
	end

	// output queue
	logic [ata_pkg::OUT_TDATA_W-1:0] fifo_din;

	assign fifo_din = {
		(ata_pkg::OUT_TDATA_W - ata_pkg::ROLL_W - ata_pkg::PITCH_W)'(0),
		pitch_s3, roll_s3};

	ata_out_fifo #(
		.W(ata_pkg::OUT_TDATA_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (en & rnd_v_s3),
		.din      (fifo_din),
		.pop      (m_tvalid & m_tready),
		.dout     (m_tdata),
		.full     (fifo_full),
		.not_empty(m_tvalid)
	);

endmodule
`default_nettype wire

// File: src/ata_sqrt_cell.sv
// one bit of the integer square root chain, carrying the sample alongside
`default_nettype none
module ata_sqrt_cell #(
	parameter int BIT = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire ata_pkg::ata_sqrt_t in_data,
	output logic                   out_valid,
	output ata_pkg::ata_sqrt_t     out_data
);

	localparam logic [ata_pkg::SQ_W-1:0] ONE_SQ = ata_pkg::SQ_W'(1) << (2 * BIT);
	localparam logic [ata_pkg::ROOT_W-1:0] ONE_ROOT = ata_pkg::ROOT_W'(1) << BIT;

	logic [ata_pkg::SQ_W-1:0] test;
	ata_pkg::ata_sqrt_t       nxt;
	logic                     valid_s1;
	ata_pkg::ata_sqrt_t       data_s1;

	always_comb begin
		test = (ata_pkg::SQ_W'(in_data.root) << (BIT + 1)) | ONE_SQ;
		nxt  = in_data;
		if (in_data.rem >= test) begin
			nxt.rem  = in_data.rem - test;
			nxt.root = in_data.root | ONE_ROOT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule
`default_nettype wire

// File: src/ata_cordic_cell.sv
// one vectoring cordic stage for the roll and pitch lanes
`default_nettype none
module ata_cordic_cell #(
	parameter int STAGE = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire ata_pkg::ata_pair_t in_data,
	output logic                   out_valid,
	output ata_pkg::ata_pair_t     out_data
);

	ata_pkg::ata_pair_t nxt;
	logic               valid_s1;
	ata_pkg::ata_pair_t data_s1;

	always_comb begin
		nxt.roll  = ata_pkg::cordic_rot(in_data.roll, STAGE);
		nxt.pitch = ata_pkg::cordic_rot(in_data.pitch, STAGE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule
`default_nettype wire

// File: src/ata_out_fifo.sv
// two-entry output queue that decouples the pipeline from the result side
`default_nettype none
module ata_out_fifo #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] din,
	input  wire logic         pop,
	output logic [W-1:0]      dout,
	output logic              full,
	output logic              not_empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	assign dout      = mem_q[rd_q];
	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);

endmodule
`default_nettype wire

// File: src/ata_checker.sv
// port-level checks for the tilt angle block, bound to its top level
`default_nettype none
`include "assert_macros.svh"
module ata_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tready,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [ata_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	`ATA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`ATA_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")
	`ATA_ASSERT_IMP(a_stall_has_result, !s_tready, m_tvalid, "input stalled with no result waiting")
	`ATA_ASSERT(a_stall_cause, !$fell(s_tready) || $past(m_tvalid && !m_tready), "input stalled without output stall")

endmodule

bind accel_tilt_angles_core ata_checker u_ata_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire

// File: sim/tb_accel_tilt_angles_core.sv
// testbench for accel_tilt_angles_core: directed and random samples against a tilt predictor
module tb_accel_tilt_angles_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC      = 8;
	localparam int STAGES    = 16;
	localparam int RAND_ITEMS = 1800;

	typedef struct {
		logic signed [ata_pkg::DATA_W-1:0] x;
		logic signed [ata_pkg::DATA_W-1:0] y;
		logic signed [ata_pkg::DATA_W-1:0] z;
	} accel_sample_t;

	typedef struct {
		accel_sample_t                      s;
		logic signed [ata_pkg::ROLL_W-1:0]  roll;
		logic signed [ata_pkg::PITCH_W-1:0] pitch;
	} tilt_t;

	typedef struct {
		accel_sample_t                      s;
		bit                                 typed;
		logic signed [ata_pkg::ROLL_W-1:0]  roll;
		logic signed [ata_pkg::PITCH_W-1:0] pitch;
	} plan_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [ata_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [ata_pkg::OUT_TDATA_W-1:0] m_tdata;

	tilt_t     pending_tilts[$];
	plan_row_t plan[$];
	int        errors = 0;
	bit        no_idle = 1'b0;
	int        stall_left = 0;

	longint atan_deg_tab [24] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
		938658, 469357, 234682, 117342, 58671, 29335,
		14668, 7334, 3667, 1833, 917, 458,
		229, 115, 57, 29, 14, 7
	};

	accel_tilt_angles_core #(
		.ANGLE_FRAC_BITS(FRAC),
		.CORDIC_STAGES(STAGES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint floor_sqrt(longint v);
		longint r;
		longint c;
		r = 0;
		for (int b = 25; b >= 0; b--) begin
			c = r | (longint'(1) << b);
			if (c * c <= v)
				r = c;
		end
		return r;
	endfunction

	// degrees with 20 fraction bits
	function automatic longint atan2_deg(longint num, longint den);
		longint x;
		longint y;
		longint a;
		longint t;
		longint xs;
		longint ys;
		if (num == 0 && den == 0)
			return 0;
		x = den * 65536;
		y = num * 65536;
		a = 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				a = 94371840;
			end else begin
				x = -y;
				y = t;
				a = -94371840;
			end
		end
		for (int i = 0; i < STAGES && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				a = a + atan_deg_tab[i];
			end else begin
				x = x - ys;
				y = y + xs;
				a = a - atan_deg_tab[i];
			end
		end
		return a;
	endfunction

	function automatic longint round_sat(longint a, longint lim_deg);
		longint v;
		longint lim;
		v = (a + (longint'(1) << (ata_pkg::ACC_FRAC - FRAC - 1))) >>>
			(ata_pkg::ACC_FRAC - FRAC);
		lim = lim_deg << FRAC;
		if (v > lim)
			v = lim;
		if (v < -lim)
			v = -lim;
		return v;
	endfunction

	function automatic tilt_t tilt_of(accel_sample_t s);
		tilt_t  t;
		longint ax;
		longint ay;
		longint az;
		longint r;
		longint v;
		ax = s.x;
		ay = s.y;
		az = s.z;
		r = floor_sqrt((ay * ay + az * az) << 16);
		t.s = s;
		v = round_sat(atan2_deg(ay, az), ata_pkg::ROLL_LIMIT_DEG);
		t.roll = v[ata_pkg::ROLL_W-1:0];
		v = round_sat(atan2_deg(-ax * 256, r), ata_pkg::PITCH_LIMIT_DEG);
		t.pitch = v[ata_pkg::PITCH_W-1:0];
		return t;
	endfunction

	function automatic plan_row_t plan_row(int x, int y, int z, bit typed = 1'b0,
			int roll = 0, int pitch = 0);
		plan_row_t p;
		p.s.x = x[ata_pkg::DATA_W-1:0];
		p.s.y = y[ata_pkg::DATA_W-1:0];
		p.s.z = z[ata_pkg::DATA_W-1:0];
		p.typed = typed;
		p.roll = roll[ata_pkg::ROLL_W-1:0];
		p.pitch = pitch[ata_pkg::PITCH_W-1:0];
		return p;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [ata_pkg::DATA_W-1:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return -16'sd1;
			3: return 16'sd1;
			default: return 16'sd0;
		endcase
	endfunction

	function automatic accel_sample_t random_sample();
		accel_sample_t s;
		s.x = 16'($urandom);
		s.y = 16'($urandom);
		s.z = 16'($urandom);
		case ($urandom_range(0, 9))
			5: begin
				s.x = 16'($signed($urandom_range(0, 15)) - 8);
				s.y = 16'($signed($urandom_range(0, 15)) - 8);
				s.z = 16'($signed($urandom_range(0, 15)) - 8);
			end
			6: begin
				if ($urandom_range(0, 1)) s.x = '0;
				if ($urandom_range(0, 1)) s.y = '0;
				if ($urandom_range(0, 1)) s.z = '0;
			end
			7: begin
				s.x = pick_extreme();
				s.y = pick_extreme();
				s.z = pick_extreme();
			end
			8: begin
				s.y = 16'($signed($urandom_range(0, 63)) - 32);
				s.z = 16'($signed($urandom_range(0, 63)) - 32);
			end
			9: s.z[ata_pkg::DATA_W-1] = 1'b1;
			default: ;
		endcase
		return s;
	endfunction

	task automatic report_mismatch(string msg);
		errors++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_sample(accel_sample_t s, bit typed, tilt_t want);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata = {s.z, s.y, s.x};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		if (typed) begin
			want.s = s;
			pending_tilts.push_back(want);
		end else begin
			pending_tilts.push_back(tilt_of(s));
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (pending_tilts.size() != 0)
			@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready = 1'b0;
			stall_left--;
		end else begin
			m_tready = 1'b1;
			if (!no_idle && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin : check_results
		tilt_t                              want;
		logic signed [ata_pkg::ROLL_W-1:0]  roll;
		logic signed [ata_pkg::PITCH_W-1:0] pitch;
		if (arst_n && m_tvalid && m_tready) begin
			roll = m_tdata[ata_pkg::ROLL_W-1:0];
			pitch = m_tdata[ata_pkg::ROLL_W+ata_pkg::PITCH_W-1:ata_pkg::ROLL_W];
			if (pending_tilts.size() == 0) begin
				report_mismatch($sformatf("unexpected result roll %0d pitch %0d",
					roll, pitch));
			end else begin
				want = pending_tilts.pop_front();
				if (roll !== want.roll)
					report_mismatch($sformatf("x %0d y %0d z %0d: roll %0d, want %0d",
						want.s.x, want.s.y, want.s.z, roll, want.roll));
				if (pitch !== want.pitch)
					report_mismatch($sformatf("x %0d y %0d z %0d: pitch %0d, want %0d",
						want.s.x, want.s.y, want.s.z, pitch, want.pitch));
			end
		end
	end

	initial begin
		#(20_000_000);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		tilt_t         want;
		accel_sample_t s;
		plan.push_back(plan_row(0, 0, 0, 1'b1, 0, 0));
		plan.push_back(plan_row(0, 0, 1));
		plan.push_back(plan_row(0, 0, -1));
		plan.push_back(plan_row(0, 1, 0));
		plan.push_back(plan_row(0, -1, 0));
		plan.push_back(plan_row(32767, 0, 0));
		plan.push_back(plan_row(-32768, 0, 0));
		plan.push_back(plan_row(-32768, -32768, -32768));
		plan.push_back(plan_row(32767, 32767, 32767));
		plan.push_back(plan_row(0, -32768, 0));
		plan.push_back(plan_row(0, 0, -32768));
		plan.push_back(plan_row(0, 32767, -32768));
		plan.push_back(plan_row(0, -32768, -32768));
		plan.push_back(plan_row(-1, 0, 0));
		plan.push_back(plan_row(1, 0, 0));
		plan.push_back(plan_row(0, -1, -1));
		plan.push_back(plan_row(0, 1, -1));
		plan.push_back(plan_row(-32768, 32767, -32768));
		plan.push_back(plan_row(32767, -32768, 32767));
		plan.push_back(plan_row(0, -32768, -1));
		plan.push_back(plan_row(0, -1, -32768));
		plan.push_back(plan_row(100, -200, 16384));
		plan.push_back(plan_row(-16384, 0, 16384));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			want.roll = plan[i].roll;
			want.pitch = plan[i].pitch;
			send_sample(plan[i].s, plan[i].typed, want);
		end
		// hold off until the pipeline is empty
		wait_drained();

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 150 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if (n == RAND_ITEMS / 2)
				wait_drained();
			s = random_sample();
			send_sample(s, 1'b0, want);
		end

		wait_drained();
		no_idle = 1'b0;
		repeat (STAGES + 40) @(negedge clk);
		if (pending_tilts.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_tilts.size()));
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/ata_pkg.sv
src/ata_sqrt_cell.sv
src/ata_cordic_cell.sv
src/ata_out_fifo.sv
src/accel_tilt_angles_core.sv
src/ata_checker.sv
sim/tb_accel_tilt_angles_core.sv
